### hdl/tsac_pkg.sv
`timescale 1ns / 1ps

package tsac_pkg;

  // Event codes carried in the func field.
  localparam logic [1:0] FUNC_CMD     = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ADDR_A      = 3'd0;
  localparam logic [2:0] REG_ADDR_B      = 3'd1;
  localparam logic [2:0] REG_DAY_LEVEL   = 3'd2;
  localparam logic [2:0] REG_NIGHT_LEVEL = 3'd3;
  localparam logic [2:0] REG_FADE_DELAY  = 3'd4;

  // Signal status codes: bits 2..1 select the aspect, bit 0 marks it waiting.
  localparam logic [2:0] HP0_ON   = 3'd0;
  localparam logic [2:0] HP0_WAIT = 3'd1;
  localparam logic [2:0] HP1_ON   = 3'd2;
  localparam logic [2:0] HP1_WAIT = 3'd3;
  localparam logic [2:0] HP2_ON   = 3'd4;
  localparam logic [2:0] HP2_WAIT = 3'd5;

  localparam logic [1:0] ASPECT_HP0 = 2'd0;
  localparam logic [1:0] ASPECT_HP1 = 2'd1;
  localparam logic [1:0] ASPECT_HP2 = 2'd2;

  localparam logic [7:0]  COUNT_MAX   = 8'd255;
  localparam logic [15:0] NO_COMMAND  = 16'hFFFF;
  localparam logic [7:0]  DAY_RESET   = 8'd255;
  localparam logic [7:0]  NIGHT_RESET = 8'd64;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] yellow;
  } lamp_set_t;

  // Writes a level to the lamps that belong to the aspect of a status code.
  function automatic lamp_set_t drive_aspect(lamp_set_t lamps, logic [2:0] status,
                                             logic [7:0] level);
    lamp_set_t result;
    result = lamps;
    case (status[2:1])
      ASPECT_HP0: result.red = level;
      ASPECT_HP1: result.green = level;
      ASPECT_HP2: begin
        result.green  = level;
        result.yellow = level;
      end
      default: ;
    endcase
    return result;
  endfunction

endpackage

### hdl/tsac_ifs.sv
`timescale 1ns / 1ps

interface tsac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] cmd_addr;

  modport source (output valid, output func, output cmd_addr, input ready);
  modport sink (input valid, input func, input cmd_addr, output ready);
endinterface

interface tsac_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lamp_red_one;
  logic [7:0] lamp_green_one;
  logic [7:0] lamp_yellow_one;
  logic [7:0] lamp_red_two;
  logic [7:0] lamp_green_two;
  logic [7:0] lamp_yellow_two;
  logic       cmd_hit;
  logic [2:0] aspect_one;
  logic [2:0] aspect_two;

  modport source (output valid, output lamp_red_one, output lamp_green_one,
                  output lamp_yellow_one, output lamp_red_two, output lamp_green_two,
                  output lamp_yellow_two, output cmd_hit, output aspect_one,
                  output aspect_two, input ready);
  modport sink (input valid, input lamp_red_one, input lamp_green_one,
                input lamp_yellow_one, input lamp_red_two, input lamp_green_two,
                input lamp_yellow_two, input cmd_hit, input aspect_one,
                input aspect_two, output ready);
endinterface

### hdl/two_signal_aspect_controller.sv
`timescale 1ns / 1ps

// Controller for two three-aspect signals (red, green, yellow lamp each).
// The in channel carries one event per item: a command address, a one-second
// tick or a refresh tick. The out channel returns exactly one item per input
// item: the six lamp target levels, the command hit flag and both statuses.
// Configuration (address tables, day and night levels, fade delay) is written
// through cfg_we / cfg_index / cfg_data; the user must do so only while the
// block is idle, as the block does not enforce it. Throughput is one item per
// cycle while results are taken; the event update is a single pass of compare
// and select logic into the state and the output register, so an item's
// result is valid after the edge that takes it. The input stays ready while
// the output register is empty or is being taken, so a stalled receiver holds
// the in channel after one item. Reset puts both signals in HP0 waiting with
// a saturated seconds count, all lamps dark, day mode, and the configuration
// at its defaults; the first item therefore lights HP0 red on both signals.
module two_signal_aspect_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  tsac_in_if.sink             in_ch,
  tsac_out_if.source          out_ch
);
  import tsac_pkg::*;

  // Configuration registers.
  logic [63:0] addr_table_a;
  logic [63:0] addr_table_b;
  logic [7:0]  day_level;
  logic [7:0]  night_level;
  logic [6:0]  fade_delay;

  // Controller state.
  logic [2:0]  status [2];
  logic [7:0]  elapsed [2];
  lamp_set_t   lamp [2];
  logic        night_mode;
  logic [15:0] last_cmd;

  logic [2:0]  status_next [2];
  logic [7:0]  elapsed_next [2];
  lamp_set_t   lamp_next [2];
  logic        night_mode_next;
  logic [15:0] last_cmd_next;
  logic        hit_next;

  // Output register.
  logic        out_valid;
  lamp_set_t   out_lamp [2];
  logic        out_hit;
  logic [2:0]  out_status [2];

  logic        in_acc;
  logic [15:0] aspect_addr [2][3];
  logic [15:0] day_addr;
  logic [15:0] night_mode_addr;
  logic [7:0]  need;
  logic [7:0]  level_now;
  logic [7:0]  level_new;
  logic        found;
  logic        sel_sig;
  logic [1:0]  sel_asp;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign aspect_addr[0][0] = addr_table_a[15:0];
  assign aspect_addr[0][1] = addr_table_a[31:16];
  assign aspect_addr[0][2] = addr_table_a[47:32];
  assign aspect_addr[1][0] = addr_table_a[63:48];
  assign aspect_addr[1][1] = addr_table_b[15:0];
  assign aspect_addr[1][2] = addr_table_b[31:16];
  assign day_addr          = addr_table_b[47:32];
  assign night_mode_addr   = addr_table_b[63:48];

  assign need      = ({1'b0, fade_delay} + 8'd1) << 1;
  assign level_now = night_mode ? night_level : day_level;
  assign level_new = night_mode_next ? night_level : day_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_table_a <= '0;
      addr_table_b <= '0;
      day_level    <= DAY_RESET;
      night_level  <= NIGHT_RESET;
      fade_delay   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADDR_A:      addr_table_a <= cfg_data;
        REG_ADDR_B:      addr_table_b <= cfg_data;
        REG_DAY_LEVEL:   day_level    <= cfg_data[7:0];
        REG_NIGHT_LEVEL: night_level  <= cfg_data[7:0];
        REG_FADE_DELAY:  fade_delay   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // First matching aspect address, in table order.
  always_comb begin
    found   = 1'b0;
    sel_sig = 1'b0;
    sel_asp = ASPECT_HP0;
    for (int s = 0; s < 2; s++) begin
      for (int a = 0; a < 3; a++) begin
        if (!found && in_ch.cmd_addr == aspect_addr[s][a]) begin
          found   = 1'b1;
          sel_sig = 1'(s);
          sel_asp = 2'(a);
        end
      end
    end
  end

  always_comb begin
    status_next     = status;
    elapsed_next    = elapsed;
    lamp_next       = lamp;
    night_mode_next = night_mode;
    last_cmd_next   = last_cmd;
    hit_next        = 1'b0;

    case (in_ch.func)
      FUNC_REFRESH: begin
        for (int s = 0; s < 2; s++) begin
          if (!status[s][0]) begin
            lamp_next[s] = drive_aspect(lamp[s], status[s], level_now);
          end
        end
      end
      FUNC_TICK: begin
        for (int s = 0; s < 2; s++) begin
          if (elapsed[s] != COUNT_MAX) begin
            elapsed_next[s] = elapsed[s] + 8'd1;
          end
        end
      end
      FUNC_CMD: begin
        if (in_ch.cmd_addr != last_cmd) begin
          last_cmd_next = in_ch.cmd_addr;
          if (in_ch.cmd_addr == day_addr) begin
            hit_next        = 1'b1;
            night_mode_next = 1'b0;
          end else if (in_ch.cmd_addr == night_mode_addr) begin
            hit_next        = 1'b1;
            night_mode_next = 1'b1;
          end else if (found) begin
            hit_next = 1'b1;
            // A request for the aspect already shown or pending changes nothing.
            if (status[sel_sig][2:1] != sel_asp) begin
              if (!status[sel_sig][0]) begin
                lamp_next[sel_sig] = drive_aspect(lamp[sel_sig], status[sel_sig], 8'd0);
              end
              status_next[sel_sig]  = {sel_asp, 1'b1};
              elapsed_next[sel_sig] = '0;
            end
          end
        end
      end
      default: ;
    endcase

    // A waiting aspect lights once its delay has run out.
    for (int s = 0; s < 2; s++) begin
      if (status_next[s][0] && elapsed_next[s] >= need) begin
        lamp_next[s]   = drive_aspect(lamp_next[s], status_next[s], level_new);
        status_next[s] = status_next[s] - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        status[s]  <= HP0_WAIT;
        elapsed[s] <= COUNT_MAX;
        lamp[s]    <= '0;
      end
      night_mode <= 1'b0;
      last_cmd   <= NO_COMMAND;
    end else if (in_acc) begin
      status     <= status_next;
      elapsed    <= elapsed_next;
      lamp       <= lamp_next;
      night_mode <= night_mode_next;
      last_cmd   <= last_cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_acc || (out_valid && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_lamp   <= lamp_next;
      out_hit    <= hit_next;
      out_status <= status_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.lamp_red_one    = out_lamp[0].red;
  assign out_ch.lamp_green_one  = out_lamp[0].green;
  assign out_ch.lamp_yellow_one = out_lamp[0].yellow;
  assign out_ch.lamp_red_two    = out_lamp[1].red;
  assign out_ch.lamp_green_two  = out_lamp[1].green;
  assign out_ch.lamp_yellow_two = out_lamp[1].yellow;
  assign out_ch.cmd_hit         = out_hit;
  assign out_ch.aspect_one      = out_status[0];
  assign out_ch.aspect_two      = out_status[1];

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    status[0] <= HP2_WAIT && status[1] <= HP2_WAIT)
    else $error("signal status out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted item produced no result");

  a_repeat_no_hit: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.func == FUNC_CMD && in_ch.cmd_addr == last_cmd) |=> !out_ch.cmd_hit)
    else $error("repeated command reported a hit");

  a_tick_monotonic: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.func == FUNC_TICK) |=>
      (elapsed[0] >= $past(elapsed[0]) && elapsed[1] >= $past(elapsed[1])))
    else $error("seconds count dropped on a tick");
`endif

endmodule

### bench/two_signal_aspect_controller_tb.sv
`timescale 1ns / 1ps

module two_signal_aspect_controller_tb;
  import tsac_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 290;
  localparam int DIRECTED_ROWS = 25;
  // Rows before this one run with the reset address tables.
  localparam int MAPPED_FROM = 4;

  // func code 3 carries no event.
  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [15:0] S1_HP0 = 16'h1000;
  localparam logic [15:0] S1_HP1 = 16'h1001;
  localparam logic [15:0] S1_HP2 = 16'h1002;
  localparam logic [15:0] S2_HP0 = 16'h2000;
  localparam logic [15:0] S2_HP1 = 16'h2001;
  localparam logic [15:0] S2_HP2 = 16'h2002;
  localparam logic [15:0] DAY_ADDR = 16'h3000;
  localparam logic [15:0] NIGHT_CMD = 16'h3001;

  typedef struct packed {
    logic [7:0] red_one;
    logic [7:0] green_one;
    logic [7:0] yellow_one;
    logic [7:0] red_two;
    logic [7:0] green_two;
    logic [7:0] yellow_two;
    logic       cmd_hit;
    logic [2:0] aspect_one;
    logic [2:0] aspect_two;
  } aspect_result_t;

  typedef struct packed {
    logic [1:0]     fn;
    logic [15:0]    addr;
    logic           pin;
    aspect_result_t res;
  } stim_row_t;

  localparam aspect_result_t NO_PIN = '0;
  localparam aspect_result_t RED_BOTH =
    '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, HP0_ON, HP0_ON};
  localparam aspect_result_t RED_BOTH_HIT =
    '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1, HP0_ON, HP0_ON};

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_TICK,    16'h0000,   1'b1, RED_BOTH},
    '{FUNC_CMD,     16'h0000,   1'b1, RED_BOTH_HIT},
    '{FUNC_CMD,     16'h0000,   1'b1, RED_BOTH},
    '{FUNC_CMD,     16'hFFFF,   1'b0, NO_PIN},
    '{FUNC_CMD,     S1_HP1,     1'b0, NO_PIN},
    '{FUNC_TICK,    16'h0000,   1'b0, NO_PIN},
    '{FUNC_TICK,    16'h0000,   1'b0, NO_PIN},
    '{FUNC_CMD,     S1_HP1,     1'b0, NO_PIN},
    '{FUNC_CMD,     S2_HP0,     1'b0, NO_PIN},
    '{FUNC_CMD,     NIGHT_CMD,  1'b0, NO_PIN},
    '{FUNC_REFRESH, 16'h0000,   1'b0, NO_PIN},
    '{FUNC_CMD,     S1_HP2,     1'b0, NO_PIN},
    '{FUNC_TICK,    16'hFFFF,   1'b0, NO_PIN},
    '{FUNC_TICK,    16'h0000,   1'b0, NO_PIN},
    '{FUNC_CMD,     DAY_ADDR,   1'b0, NO_PIN},
    '{FUNC_REFRESH, 16'hFFFF,   1'b0, NO_PIN},
    '{FUNC_NONE,    16'hA5A5,   1'b0, NO_PIN},
    '{FUNC_CMD,     S2_HP2,     1'b0, NO_PIN},
    '{FUNC_CMD,     S2_HP1,     1'b0, NO_PIN},
    '{FUNC_TICK,    16'h0000,   1'b0, NO_PIN},
    '{FUNC_TICK,    16'h0000,   1'b0, NO_PIN},
    '{FUNC_CMD,     S1_HP0,     1'b0, NO_PIN},
    '{FUNC_CMD,     16'h0000,   1'b0, NO_PIN},
    '{FUNC_TICK,    16'h0000,   1'b0, NO_PIN},
    '{FUNC_REFRESH, 16'h0000,   1'b0, NO_PIN}
  };

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  tsac_in_if  in_ch ();
  tsac_out_if out_ch ();

  two_signal_aspect_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor copy of the configuration and the signal state.
  logic [63:0] addr_lo;
  logic [63:0] addr_hi;
  logic [7:0]  day_lvl;
  logic [7:0]  night_lvl;
  logic [6:0]  delay_cfg;
  logic [2:0]  sig_state [2];
  logic [7:0]  sig_secs [2];
  logic [7:0]  lamp_lvl [6];
  logic        night_on;
  logic [15:0] last_addr;

  aspect_result_t lamp_results_due [$];
  aspect_result_t predicted;
  aspect_result_t want;
  aspect_result_t in_pinned_res;
  logic           in_pinned;

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] active_level();
    return night_on ? night_lvl : day_lvl;
  endfunction

  function automatic logic [15:0] table_entry(int idx);
    logic [63:0] word;
    word = (idx < 4) ? addr_lo : addr_hi;
    return word[(idx % 4) * 16 +: 16];
  endfunction

  // Puts a level on the lamps that make up the aspect of a status code.
  function automatic void set_aspect_lamps(int sig, logic [2:0] st, logic [7:0] level);
    int base;
    base = sig * 3;
    case (st[2:1])
      ASPECT_HP0: lamp_lvl[base] = level;
      ASPECT_HP1: lamp_lvl[base + 1] = level;
      ASPECT_HP2: begin
        lamp_lvl[base + 1] = level;
        lamp_lvl[base + 2] = level;
      end
      default: ;
    endcase
  endfunction

  function automatic void request_aspect(int sig, logic [1:0] asp);
    if (sig_state[sig][2:1] == asp) return;
    // Only a lit aspect has lamps to darken; a waiting one never lit them.
    if (!sig_state[sig][0]) set_aspect_lamps(sig, sig_state[sig], 8'd0);
    sig_state[sig] = {asp, 1'b1};
    sig_secs[sig] = 8'd0;
  endfunction

  function automatic aspect_result_t advance_signals(logic [1:0] fn, logic [15:0] addr);
    aspect_result_t r;
    logic hit;
    logic found;
    int need;
    hit = 1'b0;
    found = 1'b0;
    need = (int'(delay_cfg) + 1) * 2;
    case (fn)
      FUNC_REFRESH: begin
        for (int s = 0; s < 2; s++)
          if (!sig_state[s][0]) set_aspect_lamps(s, sig_state[s], active_level());
      end
      FUNC_TICK: begin
        for (int s = 0; s < 2; s++)
          if (sig_secs[s] != COUNT_MAX) sig_secs[s] = sig_secs[s] + 8'd1;
      end
      FUNC_CMD: begin
        if (addr != last_addr) begin
          last_addr = addr;
          if (addr == table_entry(6)) begin
            hit = 1'b1;
            night_on = 1'b0;
          end else if (addr == table_entry(7)) begin
            hit = 1'b1;
            night_on = 1'b1;
          end else begin
            for (int i = 0; i < 6; i++) begin
              if (!found && addr == table_entry(i)) begin
                found = 1'b1;
                request_aspect(i / 3, 2'(i % 3));
              end
            end
            hit = found;
          end
        end
      end
      default: ;
    endcase
    for (int s = 0; s < 2; s++) begin
      if (sig_state[s][0] && int'(sig_secs[s]) >= need) begin
        set_aspect_lamps(s, sig_state[s], active_level());
        sig_state[s] = sig_state[s] - 3'd1;
      end
    end
    r.red_one = lamp_lvl[0];
    r.green_one = lamp_lvl[1];
    r.yellow_one = lamp_lvl[2];
    r.red_two = lamp_lvl[3];
    r.green_two = lamp_lvl[4];
    r.yellow_two = lamp_lvl[5];
    r.cmd_hit = hit;
    r.aspect_one = sig_state[0];
    r.aspect_two = sig_state[1];
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Every accepted item is run through the predictor at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predicted = advance_signals(in_ch.func, in_ch.cmd_addr);
      lamp_results_due.push_back(in_pinned ? in_pinned_res : predicted);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (lamp_results_due.size() == 0) begin
        $display("%0t: result item with nothing expected, expected none, actual %0d",
                 $time, out_ch.aspect_one);
        mismatches++;
      end else begin
        want = lamp_results_due.pop_front();
        compare_field("lamp_red_one", want.red_one, out_ch.lamp_red_one);
        compare_field("lamp_green_one", want.green_one, out_ch.lamp_green_one);
        compare_field("lamp_yellow_one", want.yellow_one, out_ch.lamp_yellow_one);
        compare_field("lamp_red_two", want.red_two, out_ch.lamp_red_two);
        compare_field("lamp_green_two", want.green_two, out_ch.lamp_green_two);
        compare_field("lamp_yellow_two", want.yellow_two, out_ch.lamp_yellow_two);
        compare_field("cmd_hit", want.cmd_hit, out_ch.cmd_hit);
        compare_field("aspect_one", want.aspect_one, out_ch.aspect_one);
        compare_field("aspect_two", want.aspect_two, out_ch.aspect_two);
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer_event(logic [1:0] fn, logic [15:0] addr, logic pin,
                             aspect_result_t pin_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.cmd_addr <= addr;
    in_pinned <= pin;
    in_pinned_res <= pin_res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (lamp_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // The caller lowers cfg_we after its last write.
  task automatic write_register(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ADDR_A: addr_lo = val;
      REG_ADDR_B: addr_hi = val;
      REG_DAY_LEVEL: day_lvl = val[7:0];
      REG_NIGHT_LEVEL: night_lvl = val[7:0];
      REG_FADE_DELAY: delay_cfg = val[6:0];
      default: ;
    endcase
  endtask

  initial begin
    logic [15:0] phase_addr [8];
    logic [1:0]  fn;
    logic [15:0] addr;
    logic [7:0]  day_val;
    logic [7:0]  night_val;
    logic [6:0]  delay_val;
    int          tick_pct;
    int          r;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ADDR_A;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_CMD;
    in_ch.cmd_addr = '0;
    in_pinned = 1'b0;
    in_pinned_res = NO_PIN;

    addr_lo = '0;
    addr_hi = '0;
    day_lvl = DAY_RESET;
    night_lvl = NIGHT_RESET;
    delay_cfg = '0;
    for (int s = 0; s < 2; s++) begin
      sig_state[s] = HP0_WAIT;
      sig_secs[s] = COUNT_MAX;
    end
    for (int i = 0; i < 6; i++) lamp_lvl[i] = '0;
    night_on = 1'b0;
    last_addr = NO_COMMAND;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == MAPPED_FROM) begin
        wait_for_results();
        write_register(REG_ADDR_A, {S2_HP0, S1_HP2, S1_HP1, S1_HP0});
        write_register(REG_ADDR_B, {NIGHT_CMD, DAY_ADDR, S2_HP2, S2_HP1});
        cfg_we <= 1'b0;
      end
      offer_event(directed_rows[i].fn, directed_rows[i].addr, directed_rows[i].pin,
                  directed_rows[i].res);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      for (int i = 0; i < 8; i++) phase_addr[i] = 16'($urandom_range(65535));
      day_val = 8'($urandom_range(255));
      night_val = 8'($urandom_range(255));
      tick_pct = 35;
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          day_val = 8'd255;
          night_val = 8'd0;
          delay_val = 7'd0;
        end
        1: begin
          send_idle_pct = 72;
          recv_stall_pct = 0;
          day_val = 8'd0;
          night_val = 8'd255;
          delay_val = 7'd1;
          for (int i = 0; i < 4; i++) phase_addr[i] = 16'hFFFF;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 72;
          delay_val = 7'd3;
          for (int i = 4; i < 8; i++) phase_addr[i] = 16'h0000;
        end
        3: begin
          // The longest delay used here needs long runs of ticks to light anything.
          send_idle_pct = 33;
          recv_stall_pct = 33;
          delay_val = 7'd126;
          tick_pct = 80;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          delay_val = 7'($urandom_range(2));
        end
      endcase
      write_register(REG_ADDR_A, {phase_addr[3], phase_addr[2], phase_addr[1], phase_addr[0]});
      write_register(REG_ADDR_B, {phase_addr[7], phase_addr[6], phase_addr[5], phase_addr[4]});
      write_register(REG_DAY_LEVEL, {56'd0, day_val});
      write_register(REG_NIGHT_LEVEL, {56'd0, night_val});
      write_register(REG_FADE_DELAY, {57'd0, delay_val});
      cfg_we <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == PHASES - 1 && n == 100) hold_token <= hold_token + 1;
        if (phase == PHASES - 1 && n == 200) wait_for_results();
        r = $urandom_range(99);
        addr = 16'($urandom_range(65535));
        if (r < 88 - tick_pct) begin
          fn = FUNC_CMD;
          // Mostly known addresses so that aspects and modes keep changing.
          if ($urandom_range(7) != 0) addr = phase_addr[$urandom_range(7)];
        end else if (r < 88) begin
          fn = FUNC_TICK;
        end else if (r < 98) begin
          fn = FUNC_REFRESH;
        end else begin
          fn = FUNC_NONE;
        end
        offer_event(fn, addr, 1'b0, NO_PIN);
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/tsac_pkg.sv
hdl/tsac_ifs.sv
hdl/two_signal_aspect_controller.sv
bench/two_signal_aspect_controller_tb.sv
